// ----- hw/rtl/sadbm_pkg.sv -----
// sadbm_pkg: shared types and constants for the SAD block matching disparity core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sadbm_pkg;

   localparam int unsigned CFG_ADDR_W = 3;
   localparam int unsigned CFG_DATA_W = 11;

   // configuration register indexes
   localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_SIZE   = 3'd2;
   localparam logic [CFG_ADDR_W-1:0] REG_LEFT_SCAN    = 3'd3;
   localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_SCAN   = 3'd4;

   // request commands
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic       command;
      logic [9:0] row;
      logic [9:0] col;
      logic [7:0] left_pixel;
      logic [7:0] right_pixel;
   } req_type;

   typedef struct packed {
      logic signed [16:0] disparity_q8;
      logic               refined;
      logic [15:0]        best_cost;
   } rsp_type;

endpackage
`default_nettype wire

// ----- hw/rtl/sad_block_match_disparity_core.sv -----
// SAD stereo block matching core with parabolic sub-pixel refinement.
// Depends on sadbm_pkg, sadbm_ram, sadbm_divider.
// Load request: written into both image stores, no response.
// Query request: per candidate offset the template's pixel pairs are read through the single read port of
// each image store, plus setup, refinement reads of the cost line and the divider.
// One query at a time.
// Reset (synchronous, active high) clears control and loads register defaults; stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sad_block_match_disparity_core #(
   parameter int MAX_WIDTH      = 1024,
   parameter int MAX_HEIGHT     = 1024,
   parameter int MAX_HALF_BLOCK = 7,
   parameter int MAX_SCAN       = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire sadbm_pkg::req_type               req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output sadbm_pkg::rsp_type                    rsp_data,
   input  wire logic                             csr_wr_en,
   input  wire logic [sadbm_pkg::CFG_ADDR_W-1:0] csr_index,
   input  wire logic [sadbm_pkg::CFG_DATA_W-1:0] csr_wdata
);
   import sadbm_pkg::*;

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int AW    = XW + YW;
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int LDEP  = 2 * MAX_SCAN + 1;
   localparam int LW    = $clog2(LDEP);
   localparam int CW    = 24; // signed coordinate math
   localparam int HW    = 5;  // half block / template counters

   typedef enum logic [3:0] {
      S_IDLE, S_SETUP1, S_SETUP2, S_SUM, S_DRAIN, S_NEXT,
      S_RD1, S_RD2, S_RD3, S_CALC, S_DIV, S_OUT
   } state_type;

   // configuration
   logic [10:0] width_ff, height_ff;
   logic [3:0]  bsize_ff;
   logic [6:0]  lscan_ff, rscan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 11'd480;
         bsize_ff  <= 4'd5;
         lscan_ff  <= 7'd16;
         rscan_ff  <= 7'd16;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            REG_BLOCK_SIZE:   bsize_ff  <= csr_wdata[3:0];
            REG_LEFT_SCAN:    lscan_ff  <= csr_wdata[6:0];
            REG_RIGHT_SCAN:   rscan_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // effective configuration
   logic signed [CW-1:0] w_eff, h_eff, half_eff, l_eff, r_eff;
   always_comb begin
      logic [3:0] hb;
      hb = (bsize_ff == 4'd0) ? 4'd0 : 4'((bsize_ff - 4'd1) >> 1);
      w_eff = (width_ff == 11'd0) ? CW'(1) :
              (int'(width_ff) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_ff);
      h_eff = (height_ff == 11'd0) ? CW'(1) :
              (int'(height_ff) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(height_ff);
      half_eff = (int'(hb) > MAX_HALF_BLOCK) ? CW'(MAX_HALF_BLOCK) : CW'(hb);
      l_eff = (int'(lscan_ff) > MAX_SCAN) ? CW'(MAX_SCAN) : CW'(lscan_ff);
      r_eff = (int'(rscan_ff) > MAX_SCAN) ? CW'(MAX_SCAN) : CW'(rscan_ff);
   end

   // query geometry registers
   state_type            state_ff;
   logic signed [CW-1:0] x_ff, y_ff, lh_ff, rh_ff, th_ff, bh_ff;
   logic signed [CW-1:0] tw_ff, tht_ff, top_ff, lx_ff, rs_ff, n_ff, zero_ff;
   logic signed [CW-1:0] k_ff, best_ff;
   logic [HW-1:0]        i_ff, j_ff;
   logic [15:0]          sum_ff, best_sad_ff;
   logic                 rd_vld_ff;
   logic [15:0]          c1_ff, c2_ff, c3_ff;
   logic signed [CW-1:0] q_ff;
   logic                 div_start_ff;
   rsp_type              res_ff;
   rsp_type              rsp_ff;
   logic                 rsp_vld_ff;

   // stores
   logic          ld_en;
   logic [AW-1:0] ld_addr, l_raddr, r_raddr;
   logic [7:0]    l_rdata, r_rdata;

   assign ld_en   = req_valid && !req_stall && req_data.command == CMD_LOAD &&
                    int'(req_data.row) < MAX_HEIGHT && int'(req_data.col) < MAX_WIDTH;
   assign ld_addr = {YW'(req_data.row), XW'(req_data.col)};

   sadbm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_left (
      .clock(clock), .wr_en(ld_en), .wr_addr(ld_addr), .wr_data(req_data.left_pixel),
      .rd_addr(l_raddr), .rd_data(l_rdata));
   sadbm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_right (
      .clock(clock), .wr_en(ld_en), .wr_addr(ld_addr), .wr_data(req_data.right_pixel),
      .rd_addr(r_raddr), .rd_data(r_rdata));

   // cost line memory
   logic          cl_we;
   logic [LW-1:0] cl_waddr, cl_raddr;
   logic [15:0]   cl_rdata;
   sadbm_ram #(.WIDTH(16), .DEPTH(LDEP)) u_cost (
      .clock(clock), .wr_en(cl_we), .wr_addr(cl_waddr), .wr_data(sum_ff),
      .rd_addr(cl_raddr), .rd_data(cl_rdata));

   // pixel address for current template position
   logic signed [CW-1:0] pr, plc, prc;
   always_comb begin
      pr  = top_ff + CW'(i_ff);
      plc = lx_ff + CW'(j_ff);
      prc = rs_ff + k_ff + CW'(j_ff);
      l_raddr = {YW'(pr), XW'(plc)};
      r_raddr = {YW'(pr), XW'(prc)};
   end

   // divider for parabolic correction: (256*|num| + den) / (2*den)
   logic [25:0] div_numer, div_quot;
   logic [18:0] div_denom;
   logic        div_done;
   logic signed [17:0] num_s, den_s;
   logic [16:0] num_mag;
   always_comb begin
      num_s   = 18'(signed'({1'b0, c3_ff})) - 18'(signed'({1'b0, c1_ff}));
      den_s   = 18'(signed'({1'b0, c1_ff})) + 18'(signed'({1'b0, c3_ff}))
                - 18'(signed'({1'b0, c2_ff, 1'b0}));
      num_mag = num_s[17] ? 17'(-num_s) : 17'(num_s);
      div_numer = {num_mag, 8'd0} + 26'(den_s[16:0]);
      div_denom = {den_s[17:0], 1'b0};
   end

   sadbm_divider #(.NW(26), .DW(19)) u_div (
      .clock(clock), .reset(reset), .start(div_start_ff), .numer(div_numer),
      .denom(div_denom), .done(div_done), .quot(div_quot));

   // control sequencer
   logic [15:0] absdiff;
   assign absdiff = (l_rdata > r_rdata) ? 16'(l_rdata - r_rdata) : 16'(r_rdata - l_rdata);

   logic last_px;
   assign last_px = (CW'(j_ff) == tw_ff - 1) && (CW'(i_ff) == tht_ff - 1);

   assign cl_we    = (state_ff == S_NEXT);
   assign cl_waddr = LW'(k_ff);
   assign cl_raddr = (state_ff == S_RD1) ? LW'(best_ff - 1) :
                     (state_ff == S_RD2) ? LW'(best_ff) : LW'(best_ff + 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_vld_ff   <= 1'b0;
         rd_vld_ff    <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         if (rsp_vld_ff && !rsp_stall) rsp_vld_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_data.command == CMD_QUERY) begin
                  x_ff <= (CW'(req_data.col) < w_eff - CW'(1)) ? CW'(req_data.col)
                                                              : w_eff - CW'(1);
                  y_ff <= (CW'(req_data.row) < h_eff - CW'(1)) ? CW'(req_data.row)
                                                              : h_eff - CW'(1);
                  state_ff <= S_SETUP1;
               end
            end
            S_SETUP1: begin
               lh_ff <= (x_ff < half_eff) ? x_ff : half_eff;
               rh_ff <= (w_eff - x_ff - CW'(1) < half_eff) ? w_eff - x_ff - CW'(1) : half_eff;
               th_ff <= (y_ff < half_eff) ? y_ff : half_eff;
               bh_ff <= (h_eff - y_ff - CW'(1) < half_eff) ? h_eff - y_ff - CW'(1) : half_eff;
               state_ff <= S_SETUP2;
            end
            S_SETUP2: begin
               logic signed [CW-1:0] tw, rs, re;
               tw = lh_ff + rh_ff + CW'(1);
               rs = (x_ff - l_eff - lh_ff > 0) ? x_ff - l_eff - lh_ff : CW'(0);
               re = (w_eff - tw < x_ff + r_eff - lh_ff) ? w_eff - tw : x_ff + r_eff - lh_ff;
               tw_ff   <= tw;
               tht_ff  <= th_ff + bh_ff + CW'(1);
               top_ff  <= y_ff - th_ff;
               lx_ff   <= x_ff - lh_ff;
               rs_ff   <= rs;
               n_ff    <= re - rs;
               zero_ff <= x_ff - rs - lh_ff;
               k_ff    <= '0;
               best_ff <= '0;
               best_sad_ff <= '0;
               i_ff <= '0;
               j_ff <= '0;
               sum_ff <= '0;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               // issue one pixel pair per cycle
               rd_vld_ff  <= 1'b1;
               if (rd_vld_ff) sum_ff <= sum_ff + absdiff;
               if (last_px) begin
                  state_ff <= S_DRAIN;
               end else if (CW'(j_ff) == tw_ff - 1) begin
                  j_ff <= '0;
                  i_ff <= i_ff + 1'b1;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               sum_ff   <= sum_ff + absdiff;
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if (k_ff == 0 || sum_ff < best_sad_ff) begin
                  best_sad_ff <= sum_ff;
                  best_ff     <= k_ff;
               end
               i_ff <= '0;
               j_ff <= '0;
               sum_ff <= '0;
               if (k_ff >= n_ff || k_ff == CW'(LDEP - 1)) begin
                  state_ff <= S_RD1;
               end else begin
                  k_ff     <= k_ff + CW'(1);
                  state_ff <= S_SUM;
               end
            end
            S_RD1: state_ff <= S_RD2;
            S_RD2: begin
               c1_ff    <= cl_rdata;
               state_ff <= S_RD3;
            end
            S_RD3: begin
               c2_ff    <= cl_rdata;
               state_ff <= S_CALC;
            end
            S_CALC: begin
               logic signed [CW-1:0] d;
               c3_ff <= cl_rdata;
               d = best_ff - zero_ff;
               if (d < 0) d = -d;
               q_ff <= d <<< 8;
               if (best_ff == 0 || best_ff == n_ff || best_sad_ff == 16'd0) begin
                  res_ff.disparity_q8 <= 17'(d <<< 8);
                  res_ff.refined      <= 1'b0;
                  res_ff.best_cost    <= best_sad_ff;
                  state_ff            <= S_OUT;
               end else begin
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV;
               end
            end
            S_DIV: begin
               // the three costs were latched by S_CALC; divider runs on operands formed from them
               if (div_done) begin
                  if (den_s > 0) begin
                     res_ff.disparity_q8 <= num_s[17] ? 17'(q_ff + CW'(div_quot))
                                                      : 17'(q_ff - CW'(div_quot));
                     res_ff.refined <= 1'b1;
                  end else begin
                     res_ff.disparity_q8 <= 17'(q_ff);
                     res_ff.refined      <= 1'b0;
                  end
                  res_ff.best_cost <= best_sad_ff;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               // hand over only once the previous response has left
               if (!rsp_vld_ff || !rsp_stall) begin
                  rsp_ff     <= res_ff;
                  rsp_vld_ff <= 1'b1;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // loads are taken only while idle; queries start from idle
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // assertions
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !req_stall) else $error("stall while idle");
   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV) else $error("divider done outside divide");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");
   a_query_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.command == CMD_QUERY) |=> state_ff == S_SETUP1)
      else $error("query not started");
endmodule
`default_nettype wire

// ----- hw/rtl/sadbm_ram.sv -----
// sadbm_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sadbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/sadbm_divider.sv -----
// sadbm_divider: restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the core for the sub-pixel correction.
`timescale 1ns / 1ps
`default_nettype none
module sadbm_divider #(
   parameter int NW = 26,
   parameter int DW = 19
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] numer,
   input  wire logic [DW-1:0] denom,
   output logic               done,
   output logic      [NW-1:0] quot
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] quot_ff, quot_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;

   // one shift-subtract step per cycle
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DW-1:0], quot_ff[NW-1]};
      if (start) begin
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[NW-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule
`default_nettype wire

// ----- tb/sad_block_match_disparity_core_tb.sv -----
// Self-checking testbench for sad_block_match_disparity_core: loads stereo frames,
// queries disparities and checks each response against a built-in SAD/parabola predictor.
// Depends on sadbm_pkg and the core RTL only.
`timescale 1ns / 1ps
module sad_block_match_disparity_core_tb;
   import sadbm_pkg::*;

   localparam int MAX_W      = 1024;
   localparam int MAX_H      = 1024;
   localparam int MAX_HALF   = 7;
   localparam int MAX_STEPS  = 64;
   localparam int LINE_LEN   = 2 * MAX_STEPS + 1;
   localparam int LIMIT      = 4_000_000;
   localparam int DRAIN      = 40;
   localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

   // frame fill patterns
   typedef enum int { FILL_NOISE, FILL_SHIFTED, FILL_FLAT } fill_kind;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic [CFG_ADDR_W-1:0] csr_index = '0;
   logic [CFG_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   bit [7:0] left_img [int];
   bit [7:0] right_img [int];
   int unsigned width_reg, height_reg, block_reg, lscan_reg, rscan_reg;
   rsp_type  pending_disp [$];

   int  mismatches = 0;
   int  cycles = 0;
   int  hold_left = 0;
   int  stall_left = 0;
   bit  calm = 1'b0;

   sad_block_match_disparity_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // cycle budget
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int imin(int a, int b);
      return a < b ? a : b;
   endfunction

   function automatic int imax(int a, int b);
      return a > b ? a : b;
   endfunction

   // expected response of one disparity query under the current registers
   function automatic rsp_type predict_disparity(int row, int col);
      int W, H, half, L, R, x, y, lh, rh, th, bh, tw, tht, top, lx, rs, re, n, zero;
      int best, d, q, c1, c2, c3, num, den, sum, a, b;
      int unsigned best_sad;
      longint corr;
      int costs [LINE_LEN];
      bit refine;
      rsp_type res;
      W = imin(imax(width_reg, 1), MAX_W);
      H = imin(imax(height_reg, 1), MAX_H);
      half = (block_reg == 0) ? 0 : (block_reg - 1) >> 1;
      half = imin(half, MAX_HALF);
      L = imin(lscan_reg, MAX_STEPS);
      R = imin(rscan_reg, MAX_STEPS);
      x = imin(col, W - 1);
      y = imin(row, H - 1);
      lh = imin(x, half);
      rh = imin(W - x - 1, half);
      th = imin(y, half);
      bh = imin(H - y - 1, half);
      tw = lh + rh + 1;
      tht = th + bh + 1;
      top = y - th;
      lx = x - lh;
      rs = imax(0, x - L - lh);
      re = imin(W - tw, x + R - lh);
      n = re - rs;
      zero = x - rs - lh;
      best = 0;
      best_sad = 0;
      for (int k = 0; k <= n && k < LINE_LEN; k++) begin
         sum = 0;
         for (int i = 0; i < tht; i++)
            for (int j = 0; j < tw; j++) begin
               a = left_img[(top + i) * MAX_W + lx + j];
               b = right_img[(top + i) * MAX_W + rs + k + j];
               sum += (a > b) ? a - b : b - a;
            end
         costs[k] = sum;
         if (k == 0 || sum < best_sad) begin
            best_sad = sum;
            best = k;
         end
      end
      d = best - zero;
      if (d < 0) d = -d;
      q = d * 256;
      refine = !(best == 0 || best == n || best_sad == 0);
      if (refine) begin
         c1 = costs[best - 1];
         c2 = costs[best];
         c3 = costs[best + 1];
         num = c3 - c1;
         den = c1 - 2 * c2 + c3;
         if (den > 0) begin
            corr = (256 * longint'(num < 0 ? -num : num) + den) / (2 * longint'(den));
            q -= int'(num < 0 ? -corr : corr);
         end else begin
            refine = 1'b0;
         end
      end
      res.disparity_q8 = q[16:0];
      res.refined = refine;
      res.best_cost = best_sad[15:0];
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // offer one request and wait until the core takes it
   task automatic send_request(req_type r);
      int gap;
      bit taken;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      if (r.command == CMD_LOAD) begin
         left_img[r.row * MAX_W + r.col] = r.left_pixel;
         right_img[r.row * MAX_W + r.col] = r.right_pixel;
      end else begin
         pending_disp.push_back(predict_disparity(r.row, r.col));
      end
   endtask

   task automatic query(int row, int col);
      req_type r;
      r = '0;
      r.command = CMD_QUERY;
      r.row = 10'(row);
      r.col = 10'(col);
      r.left_pixel = 8'($urandom);
      r.right_pixel = 8'($urandom);
      send_request(r);
   endtask

   // stop offering and let every outstanding response drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_disp.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int unsigned value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CFG_DATA_W'(value);
      @(posedge clock);
      case (idx)
         REG_IMAGE_WIDTH:  width_reg = value & 11'h7FF;
         REG_IMAGE_HEIGHT: height_reg = value & 11'h7FF;
         REG_BLOCK_SIZE:   block_reg = value & 4'hF;
         REG_LEFT_SCAN:    lscan_reg = value & 7'h7F;
         REG_RIGHT_SCAN:   rscan_reg = value & 7'h7F;
         default: ;
      endcase
   endtask

   task automatic configure(int w, int h, int bs, int ls, int rs);
      wait_idle();
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
      write_reg(REG_BLOCK_SIZE, bs);
      write_reg(REG_LEFT_SCAN, ls);
      write_reg(REG_RIGHT_SCAN, rs);
      csr_wr_en <= 1'b0;
   endtask

   // load a rectangle of pixels, rows r0..r1 and columns c0..c1
   task automatic load_window(fill_kind kind, int r0, int r1, int c0, int c1);
      int shift, flat;
      int lrow [MAX_W];
      req_type r;
      shift = $urandom_range(0, 6);
      flat = $urandom_range(0, 255);
      for (int y = r0; y <= r1; y++) begin
         for (int x = c0; x <= c1; x++)
            lrow[x] = (kind == FILL_FLAT) ? flat : $urandom_range(0, 255);
         for (int x = c0; x <= c1; x++) begin
            r.command = CMD_LOAD;
            r.row = 10'(y);
            r.col = 10'(x);
            r.left_pixel = 8'(lrow[x]);
            case (kind)
               FILL_SHIFTED: r.right_pixel = (x + shift <= c1 && $urandom_range(0, 15) != 0)
                                              ? 8'(lrow[x + shift]) : 8'($urandom_range(0, 255));
               FILL_FLAT:    r.right_pixel = 8'(flat);
               default:      r.right_pixel = 8'($urandom_range(0, 255));
            endcase
            send_request(r);
         end
      end
   endtask

   // load the whole active frame so that every query reads written pixels only
   task automatic load_frame(fill_kind kind);
      int W, H;
      W = imin(imax(width_reg, 1), MAX_W);
      H = imin(imax(height_reg, 1), MAX_H);
      load_window(kind, 0, H - 1, 0, W - 1);
   endtask

   task automatic random_queries(int count);
      int W, H;
      W = imin(imax(width_reg, 1), MAX_W);
      H = imin(imax(height_reg, 1), MAX_H);
      repeat (count) begin
         if ($urandom_range(0, 4) == 0) query($urandom_range(0, 1023), $urandom_range(0, 1023));
         else query($urandom_range(0, H - 1), $urandom_range(0, W - 1));
      end
   endtask

   // small frame, border and out-of-image queries
   task automatic test_small_frame();
      configure(12, 5, 5, 4, 4);
      calm = 1'b1;
      load_frame(FILL_SHIFTED);
      calm = 1'b0;
      query(0, 0);
      query(0, 1023);
      query(1023, 0);
      query(1023, 1023);
      query(2, 6);
      query(4, 11);
      query(1, 2);
   endtask

   // one-pixel image, zero block and zero scan, unused register index
   task automatic test_degenerate();
      configure(0, 0, 0, 0, 0);
      write_reg(REG_UNUSED, 11'h7FF);
      csr_wr_en <= 1'b0;
      query(0, 0);
      query(1023, 1023);
      query(512, 7);
   endtask

   // varied registers over the loaded frame
   task automatic test_random_configs();
      repeat (4) begin
         configure($urandom_range(1, 12), $urandom_range(1, 5), $urandom_range(0, 15),
                   $urandom_range(0, 20), $urandom_range(0, 20));
         random_queries(3);
      end
   endtask

   // largest block clipped by the frame, saturated search range
   task automatic test_large_block();
      configure(12, 5, 15, 64, 64);
      query(2, 1);
      query(4, 10);
      query(0, 5);
   endtask

   // flat patch: equal costs everywhere, first minimum and zero cost
   task automatic test_flat();
      configure(4, 2, 3, 5, 5);
      load_frame(FILL_FLAT);
      random_queries(3);
   endtask

   // widest image, one row, saturated scans at the right border
   task automatic test_wide_scan();
      configure(2047, 1, 1, 127, 127);
      load_window(FILL_SHIFTED, 0, 0, 958, 1023);
      query(0, 1023);
      query(300, 1023);
      configure(2047, 1, 3, 127, 127);
      query(0, 1023);
   endtask

   // tallest image, one column, even block size
   task automatic test_tall();
      configure(1, 2047, 14, 64, 0);
      load_window(FILL_NOISE, 1017, 1023, 0, 0);
      query(1023, 512);
      query(1023, 0);
   endtask

   // response side held off long enough that the core stalls requests
   task automatic test_backpressure();
      configure(12, 5, 1, 2, 2);
      hold_left = 600;
      calm = 1'b1;
      random_queries(8);
      calm = 1'b0;
      wait_idle();
      random_queries(6);
   endtask

   // response stall: long hold when requested, otherwise random bursts
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 3);
      end
   end

   // response checker; inputs are stable between negedge and the next posedge
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_disp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: unexpected response disp=%0d refined=%0d cost=%0d",
                        rsp_data.disparity_q8, rsp_data.refined, rsp_data.best_cost);
         end else begin
            want = pending_disp.pop_front();
            if (want.disparity_q8 !== rsp_data.disparity_q8 ||
                want.refined !== rsp_data.refined ||
                want.best_cost !== rsp_data.best_cost) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("tb: mismatch exp disp=%0d refined=%0d cost=%0d, got %0d %0d %0d",
                           want.disparity_q8, want.refined, want.best_cost,
                           rsp_data.disparity_q8, rsp_data.refined, rsp_data.best_cost);
            end
         end
      end
   end

   initial begin
      width_reg = 640;
      height_reg = 480;
      block_reg = 5;
      lscan_reg = 16;
      rscan_reg = 16;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_small_frame();
      test_degenerate();
      test_random_configs();
      test_large_block();
      test_flat();
      test_wide_scan();
      test_tall();
      test_backpressure();
      wait_idle();
      if (mismatches == 0 && pending_disp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
